/* hw/rtl/ddsr_pkg.sv */
`timescale 1ns / 1ps

package ddsr_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int STEP_W     = 10;
   localparam int PERIOD_W   = 8;
   localparam int DEADBAND_W = 7;
   localparam int TIMEOUT_W  = 16;

   localparam int TARGET_W = 11;
   localparam int CODE_W   = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_RAMP_STEP   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RAMP_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DEADBAND    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TIMEOUT     = 2'd3;

   localparam logic [STEP_W-1:0]     RAMP_STEP_RESET   = 10'd50;
   localparam logic [PERIOD_W-1:0]   RAMP_PERIOD_RESET = 8'd20;
   localparam logic [DEADBAND_W-1:0] DEADBAND_RESET    = 7'd10;
   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET     = 16'd1000;

   localparam logic MODE_TICK    = 1'b0;
   localparam logic MODE_COMMAND = 1'b1;

   localparam logic [CODE_W-1:0] WHEEL_DIRECT  = 3'd0;
   localparam logic [CODE_W-1:0] WHEEL_FORWARD = 3'd1;
   localparam logic [CODE_W-1:0] WHEEL_BACK    = 3'd2;
   localparam logic [CODE_W-1:0] WHEEL_LEFT    = 3'd3;
   localparam logic [CODE_W-1:0] WHEEL_RIGHT   = 3'd4;
   localparam logic [CODE_W-1:0] WHEEL_STOP    = 3'd5;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic is_tick;
      logic has_cmd;
   } op_type;

endpackage

/* hw/rtl/ddsr_if.sv */
`timescale 1ns / 1ps

interface ddsr_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  mode;
   logic [ddsr_pkg::CODE_W-1:0]           wheel_code;
   logic signed [ddsr_pkg::TARGET_W-1:0]  left_target;
   logic signed [ddsr_pkg::TARGET_W-1:0]  right_target;

   modport source (output valid, mode, wheel_code, left_target, right_target,
                   input ready);
   modport sink (input valid, mode, wheel_code, left_target, right_target,
                 output ready);
endinterface

interface ddsr_rsp_if #(parameter int PWM_W = 7);
   logic             valid;
   logic             ready;
   logic [PWM_W-1:0] left_pwm;
   logic [PWM_W-1:0] right_pwm;
   logic             left_forward;
   logic             right_forward;
   logic             ramp_updated;

   modport source (output valid, left_pwm, right_pwm, left_forward, right_forward,
                   ramp_updated, input ready);
   modport sink (input valid, left_pwm, right_pwm, left_forward, right_forward,
                 ramp_updated, output ready);
endinterface

/* hw/rtl/ddsr_front.sv */
`timescale 1ns / 1ps

module ddsr_front #(
   parameter int FULL_SCALE = 1000,
   parameter int CMD_W      = 11
) (
   ddsr_req_if.sink                 req_ch,
   input  logic                     full,
   output logic                     push,
   output ddsr_pkg::op_type         op,
   output logic signed [CMD_W-1:0]  left_cmd,
   output logic signed [CMD_W-1:0]  right_cmd
);
   import ddsr_pkg::*;

   localparam int EXT_W = ((CMD_W > TARGET_W) ? CMD_W : TARGET_W) + 1;
   localparam logic signed [EXT_W-1:0] POS_FS = EXT_W'(FULL_SCALE);
   localparam logic signed [EXT_W-1:0] NEG_FS = -POS_FS;
   localparam logic signed [CMD_W-1:0] CMD_FULL = CMD_W'(FULL_SCALE);
   localparam logic signed [CMD_W-1:0] CMD_NEG  = -CMD_FULL;

   function automatic logic signed [CMD_W-1:0] sat_full(
      input logic signed [TARGET_W-1:0] x
   );
      logic signed [EXT_W-1:0] xe;
      logic signed [EXT_W-1:0] r;
      xe = EXT_W'(x);
      if (xe > POS_FS) begin
         r = POS_FS;
      end else if (xe < NEG_FS) begin
         r = NEG_FS;
      end else begin
         r = xe;
      end
      return CMD_W'(r);
   endfunction

   always_comb begin
      op.is_tick = (req_ch.mode == MODE_TICK);
      op.has_cmd = 1'b0;
      left_cmd   = '0;
      right_cmd  = '0;
      if (req_ch.mode == MODE_COMMAND) begin
         op.has_cmd = 1'b1;
         case (req_ch.wheel_code)
            WHEEL_DIRECT: begin
               left_cmd  = sat_full(req_ch.left_target);
               right_cmd = sat_full(req_ch.right_target);
            end
            WHEEL_FORWARD: begin
               left_cmd  = CMD_FULL;
               right_cmd = CMD_FULL;
            end
            WHEEL_BACK: begin
               left_cmd  = CMD_NEG;
               right_cmd = CMD_NEG;
            end
            WHEEL_LEFT: begin
               left_cmd  = CMD_NEG;
               right_cmd = CMD_FULL;
            end
            WHEEL_RIGHT: begin
               left_cmd  = CMD_FULL;
               right_cmd = CMD_NEG;
            end
            WHEEL_STOP: begin
               left_cmd  = '0;
               right_cmd = '0;
            end
            default: begin
               // unused codes leave the commands alone
               op.has_cmd = 1'b0;
            end
         endcase
      end
   end

   assign req_ch.ready = !full;
   assign push         = req_ch.valid && !full;

endmodule

/* hw/rtl/ddsr_queue.sv */
`timescale 1ns / 1ps

module ddsr_queue #(
   parameter int W     = 24,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         empty,
   output logic         full
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [W-1:0]  mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == NW'(DEPTH));
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/ddsr_back.sv */
`timescale 1ns / 1ps

module ddsr_back #(
   parameter int FULL_SCALE = 1000,
   parameter int PWM_MAX    = 100,
   parameter int CMD_W      = 11,
   parameter int PWM_W      = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ddsr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ddsr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                q_empty,
   input  ddsr_pkg::op_type                    q_op,
   input  logic signed [CMD_W-1:0]             q_left_cmd,
   input  logic signed [CMD_W-1:0]             q_right_cmd,
   output logic                                q_pop,
   ddsr_rsp_if.source                          rsp_ch
);
   import ddsr_pkg::*;

   localparam int MAG_W   = CMD_W - 1;
   localparam int Q_W     = $clog2(FULL_SCALE * PWM_MAX + 1);
   localparam int SHIFT   = Q_W + $clog2(FULL_SCALE);
   localparam longint RECIP = ((longint'(1) << SHIFT) + FULL_SCALE - 1) / FULL_SCALE;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W  = Q_W + RECIP_W;
   localparam int DB_W    = (PWM_W > DEADBAND_W) ? PWM_W : DEADBAND_W;
   localparam int D_W     = ((CMD_W > STEP_W) ? CMD_W : STEP_W) + 2;
   localparam logic [Q_W-1:0]     PWM_MAX_C = Q_W'(PWM_MAX);
   localparam logic [PROD_W-1:0]  RECIP_C   = PROD_W'(RECIP);

   function automatic logic signed [CMD_W-1:0] slew(
      input logic signed [CMD_W-1:0] cur,
      input logic signed [CMD_W-1:0] cmd,
      input logic [STEP_W-1:0]       step
   );
      logic signed [D_W-1:0] curx;
      logic signed [D_W-1:0] diff;
      logic signed [D_W-1:0] s;
      logic signed [D_W-1:0] r;
      curx = D_W'(cur);
      diff = D_W'(cmd) - curx;
      s    = D_W'(step);
      if (diff > s) begin
         r = curx + s;
      end else if (diff < -s) begin
         r = curx - s;
      end else begin
         r = D_W'(cmd);
      end
      return CMD_W'(r);
   endfunction

   function automatic logic [MAG_W-1:0] mag(input logic signed [CMD_W-1:0] x);
      logic signed [CMD_W-1:0] a;
      a = (x < 0) ? -x : x;
      return MAG_W'(a);
   endfunction

   function automatic logic [PWM_W-1:0] to_pwm(
      input logic [Q_W-1:0]        q,
      input logic [DEADBAND_W-1:0] deadband
   );
      logic [PROD_W-1:0] prod;
      logic [PWM_W-1:0]  p;
      prod = PROD_W'(q) * RECIP_C;
      p    = PWM_W'(prod >> SHIFT);
      if (DB_W'(p) < DB_W'(deadband)) begin
         p = '0;
      end
      return p;
   endfunction

   // configuration
   logic [STEP_W-1:0]     step_ff;
   logic [PERIOD_W-1:0]   period_ff;
   logic [DEADBAND_W-1:0] deadband_ff;
   logic [TIMEOUT_W-1:0]  timeout_ff;

   // drive state
   logic signed [CMD_W-1:0] left_cmd_ff, left_cmd_in;
   logic signed [CMD_W-1:0] right_cmd_ff, right_cmd_in;
   logic signed [CMD_W-1:0] left_cur_ff, left_cur_in;
   logic signed [CMD_W-1:0] right_cur_ff, right_cur_in;
   logic [PERIOD_W-1:0]     ramp_cnt_ff, ramp_cnt_in;
   logic [TIMEOUT_W-1:0]    tmo_cnt_ff, tmo_cnt_in;
   logic [PERIOD_W:0]       ramp_next;
   logic [TIMEOUT_W:0]      tmo_next;
   logic                    do_ramp;
   logic                    do_timeout;
   logic                    exec_upd;

   // pipeline
   logic             p1_valid_ff;
   logic             p1_upd_ff;
   logic [MAG_W-1:0] p1_lmag_ff, p1_rmag_ff;
   logic             p1_lfwd_ff, p1_rfwd_ff;
   logic             p2_valid_ff;
   logic             p2_upd_ff;
   logic [Q_W-1:0]   p2_lq_ff, p2_rq_ff;
   logic             p2_lfwd_ff, p2_rfwd_ff;

   logic             rsp_valid_ff;
   logic             upd_ff;
   logic [PWM_W-1:0] lpwm_ff, rpwm_ff;
   logic             lfwd_ff, rfwd_ff;

   logic out_free, p2_move, p1_move;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign p2_move  = p2_valid_ff && out_free;
   assign p1_move  = p1_valid_ff && (!p2_valid_ff || p2_move);
   assign q_pop    = !q_empty && (!p1_valid_ff || p1_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= RAMP_STEP_RESET;
         period_ff   <= RAMP_PERIOD_RESET;
         deadband_ff <= DEADBAND_RESET;
         timeout_ff  <= TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_RAMP_STEP:   step_ff     <= csr_wdata[STEP_W-1:0];
            REG_RAMP_PERIOD: period_ff   <= csr_wdata[PERIOD_W-1:0];
            REG_DEADBAND:    deadband_ff <= csr_wdata[DEADBAND_W-1:0];
            REG_TIMEOUT:     timeout_ff  <= csr_wdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      ramp_next  = {1'b0, ramp_cnt_ff} + 1'b1;
      tmo_next   = {1'b0, tmo_cnt_ff} + 1'b1;
      do_ramp    = ramp_next > {1'b0, period_ff};
      do_timeout = tmo_next > {1'b0, timeout_ff};
      exec_upd   = q_op.is_tick && do_ramp;

      left_cmd_in  = left_cmd_ff;
      right_cmd_in = right_cmd_ff;
      left_cur_in  = left_cur_ff;
      right_cur_in = right_cur_ff;
      ramp_cnt_in  = ramp_cnt_ff;
      tmo_cnt_in   = tmo_cnt_ff;

      if (q_pop) begin
         if (q_op.has_cmd) begin
            left_cmd_in  = q_left_cmd;
            right_cmd_in = q_right_cmd;
         end
         if (q_op.is_tick) begin
            if (do_ramp) begin
               // slew uses the commands held before a timeout on the same tick
               ramp_cnt_in  = '0;
               left_cur_in  = slew(left_cur_ff, left_cmd_ff, step_ff);
               right_cur_in = slew(right_cur_ff, right_cmd_ff, step_ff);
            end else begin
               ramp_cnt_in = PERIOD_W'(ramp_next);
            end
            if (do_timeout) begin
               tmo_cnt_in   = '0;
               left_cmd_in  = '0;
               right_cmd_in = '0;
            end else begin
               tmo_cnt_in = TIMEOUT_W'(tmo_next);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_cmd_ff  <= '0;
         right_cmd_ff <= '0;
         left_cur_ff  <= '0;
         right_cur_ff <= '0;
         ramp_cnt_ff  <= '0;
         tmo_cnt_ff   <= '0;
      end else begin
         left_cmd_ff  <= left_cmd_in;
         right_cmd_ff <= right_cmd_in;
         left_cur_ff  <= left_cur_in;
         right_cur_ff <= right_cur_in;
         ramp_cnt_ff  <= ramp_cnt_in;
         tmo_cnt_ff   <= tmo_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            p1_valid_ff <= 1'b1;
         end else if (p1_move) begin
            p1_valid_ff <= 1'b0;
         end
         if (p1_move) begin
            p2_valid_ff <= 1'b1;
         end else if (p2_move) begin
            p2_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         p1_upd_ff  <= exec_upd;
         p1_lmag_ff <= mag(left_cur_in);
         p1_rmag_ff <= mag(right_cur_in);
         p1_lfwd_ff <= (left_cur_in > 0);
         p1_rfwd_ff <= (right_cur_in > 0);
      end
      if (p1_move) begin
         p2_upd_ff  <= p1_upd_ff;
         p2_lq_ff   <= Q_W'(p1_lmag_ff) * PWM_MAX_C;
         p2_rq_ff   <= Q_W'(p1_rmag_ff) * PWM_MAX_C;
         p2_lfwd_ff <= p1_lfwd_ff;
         p2_rfwd_ff <= p1_rfwd_ff;
      end
   end

   // held drive outputs change only on a ramp update
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         upd_ff       <= 1'b0;
         lpwm_ff      <= '0;
         rpwm_ff      <= '0;
         lfwd_ff      <= 1'b0;
         rfwd_ff      <= 1'b0;
      end else if (p2_move) begin
         rsp_valid_ff <= 1'b1;
         upd_ff       <= p2_upd_ff;
         if (p2_upd_ff) begin
            lpwm_ff <= to_pwm(p2_lq_ff, deadband_ff);
            rpwm_ff <= to_pwm(p2_rq_ff, deadband_ff);
            lfwd_ff <= p2_lfwd_ff;
            rfwd_ff <= p2_rfwd_ff;
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.left_pwm      = lpwm_ff;
   assign rsp_ch.right_pwm     = rpwm_ff;
   assign rsp_ch.left_forward  = lfwd_ff;
   assign rsp_ch.right_forward = rfwd_ff;
   assign rsp_ch.ramp_updated  = upd_ff;

endmodule

/* hw/rtl/diff_drive_slew_ramp.sv */
// path: the queue, then the p1, p2 and output registers lie between an accepted beat and its result
// throughput: one beat per cycle while the result side is ready, set by the three-stage back end
// the four-entry queue between front and back absorbs output stalls
// reset: synchronous, active high; clears commands, speeds, counters and queue,
// loads the register defaults and drives zero pwm with reverse direction
`timescale 1ns / 1ps

module diff_drive_slew_ramp #(
   parameter int FULL_SCALE = 1000,
   parameter int PWM_MAX    = 100
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ddsr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ddsr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   ddsr_req_if.sink                          req_ch,
   ddsr_rsp_if.source                        rsp_ch
);
   import ddsr_pkg::*;

   localparam int CMD_W  = $clog2(FULL_SCALE + 1) + 1;
   localparam int PWM_W  = $clog2(PWM_MAX + 1);
   localparam int ITEM_W = $bits(op_type) + 2 * CMD_W;

   logic                    push;
   op_type                  f_op;
   logic signed [CMD_W-1:0] f_left_cmd, f_right_cmd;
   logic                    q_full, q_empty, q_pop;
   logic [ITEM_W-1:0]       q_data;
   op_type                  q_op;
   logic signed [CMD_W-1:0] q_left_cmd, q_right_cmd;

   ddsr_front #(
      .FULL_SCALE (FULL_SCALE),
      .CMD_W      (CMD_W)
   ) u_front (
      .req_ch    (req_ch),
      .full      (q_full),
      .push      (push),
      .op        (f_op),
      .left_cmd  (f_left_cmd),
      .right_cmd (f_right_cmd)
   );

   ddsr_queue #(
      .W     (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_op, f_left_cmd, f_right_cmd}),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   assign {q_op, q_left_cmd, q_right_cmd} = q_data;

   ddsr_back #(
      .FULL_SCALE (FULL_SCALE),
      .PWM_MAX    (PWM_MAX),
      .CMD_W      (CMD_W),
      .PWM_W      (PWM_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_empty     (q_empty),
      .q_op        (q_op),
      .q_left_cmd  (q_left_cmd),
      .q_right_cmd (q_right_cmd),
      .q_pop       (q_pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

/* hw/rtl/ddsr_checker.sv */
`timescale 1ns / 1ps

module ddsr_checker #(
   parameter int PWM_MAX = 100,
   parameter int PWM_W   = 7
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [PWM_W-1:0] left_pwm,
   input logic [PWM_W-1:0] right_pwm,
   input logic             left_forward,
   input logic             right_forward,
   input logic             ramp_updated
);
   localparam logic [PWM_W-1:0] PWM_LIMIT = PWM_W'(PWM_MAX);

   logic [PWM_W-1:0] last_lpwm_ff, last_rpwm_ff;
   logic             last_lfwd_ff, last_rfwd_ff;

   // drive values of the last delivered beat
   always_ff @(posedge clock) begin
      if (reset) begin
         last_lpwm_ff <= '0;
         last_rpwm_ff <= '0;
         last_lfwd_ff <= 1'b0;
         last_rfwd_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         last_lpwm_ff <= left_pwm;
         last_rpwm_ff <= right_pwm;
         last_lfwd_ff <= left_forward;
         last_rfwd_ff <= right_forward;
      end
   end

   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(left_pwm) && $stable(right_pwm)
         && $stable(left_forward) && $stable(right_forward) && $stable(ramp_updated))
      else $error("stalled result beat changed");

   a_pwm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> left_pwm <= PWM_LIMIT && right_pwm <= PWM_LIMIT)
      else $error("pwm above full duty");

   a_held_outputs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !ramp_updated |-> left_pwm == last_lpwm_ff
         && right_pwm == last_rpwm_ff && left_forward == last_lfwd_ff
         && right_forward == last_rfwd_ff)
      else $error("drive outputs moved without a ramp update");

endmodule

bind diff_drive_slew_ramp ddsr_checker #(
   .PWM_MAX (PWM_MAX),
   .PWM_W   (PWM_W)
) u_ddsr_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .left_pwm      (rsp_ch.left_pwm),
   .right_pwm     (rsp_ch.right_pwm),
   .left_forward  (rsp_ch.left_forward),
   .right_forward (rsp_ch.right_forward),
   .ramp_updated  (rsp_ch.ramp_updated)
);

/* verif/tb_diff_drive_slew_ramp.sv */
`timescale 1ns / 1ps

module tb_diff_drive_slew_ramp;
   import ddsr_pkg::*;

   localparam int FULL_SPEED = 1000;
   localparam int DUTY_MAX = 100;
   localparam int RANDOM_ITEMS = 1750;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES = 150;
   localparam int unsigned CYCLE_LIMIT = 200000;

   localparam logic [CODE_W-1:0] WHEEL_SPARE_LO = 3'd6;
   localparam logic [CODE_W-1:0] WHEEL_SPARE_HI = 3'd7;

   typedef struct packed {
      logic                       mode;
      logic [CODE_W-1:0]          wheel_code;
      logic signed [TARGET_W-1:0] left_target;
      logic signed [TARGET_W-1:0] right_target;
   } drive_beat_type;

   typedef struct packed {
      logic [6:0] left_pwm;
      logic [6:0] right_pwm;
      logic       left_forward;
      logic       right_forward;
      logic       ramp_updated;
   } drive_out_type;

   typedef struct packed {
      logic [STEP_W-1:0]     step;
      logic [PERIOD_W-1:0]   period;
      logic [DEADBAND_W-1:0] deadband;
      logic [TIMEOUT_W-1:0]  timeout;
   } ramp_settings_type;

   typedef enum logic {ROW_BEAT, ROW_SETTINGS} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      drive_beat_type    beat;
      ramp_settings_type settings;
      logic              known;
      drive_out_type     result;
   } directed_row_type;

   typedef struct packed {
      logic          known;
      drive_out_type result;
   } row_note_type;

   localparam ramp_settings_type KEEP = '0;
   localparam drive_out_type ANY = '0;
   localparam drive_out_type STILL = '0;
   localparam drive_out_type FULL_SPLIT_HELD = '{7'd100, 7'd100, 1'b1, 1'b0, 1'b0};
   localparam drive_out_type FULL_SPLIT_RAMP = '{7'd100, 7'd100, 1'b1, 1'b0, 1'b1};
   localparam drive_beat_type TICK = '{MODE_TICK, WHEEL_DIRECT, 11'sd0, 11'sd0};

   localparam ramp_settings_type SET_FAST = '{10'd1000, 8'd0, 7'd0, 16'd65535};
   localparam ramp_settings_type SET_NO_STEP = '{10'd0, 8'd0, 7'd0, 16'd65535};
   localparam ramp_settings_type SET_DEADBAND = '{10'd7, 8'd0, 7'd100, 16'd65535};
   localparam ramp_settings_type SET_QUICK_TIMEOUT = '{10'd300, 8'd1, 7'd0, 16'd1};

   localparam int DIRECTED_ROWS = 29;
   localparam directed_row_type directed_rows[DIRECTED_ROWS] = '{
      '{ROW_BEAT, TICK, KEEP, 1'b1, STILL},
      '{ROW_BEAT, '{MODE_COMMAND, WHEEL_DIRECT, 11'h3FF, 11'h400}, KEEP, 1'b1, STILL},
      '{ROW_SETTINGS, TICK, SET_FAST, 1'b0, ANY},
      '{ROW_BEAT, TICK, KEEP, 1'b1, FULL_SPLIT_RAMP},
      '{ROW_BEAT, '{MODE_COMMAND, WHEEL_SPARE_LO, 11'sd5, 11'sd5}, KEEP, 1'b1,
        FULL_SPLIT_HELD},
      '{ROW_BEAT, '{MODE_COMMAND, WHEEL_SPARE_HI, -11'sd5, -11'sd5}, KEEP, 1'b1,
        FULL_SPLIT_HELD},
      '{ROW_BEAT, TICK, KEEP, 1'b1, FULL_SPLIT_RAMP},
      '{ROW_BEAT, '{MODE_COMMAND, WHEEL_BACK, 11'sd0, 11'sd0}, KEEP, 1'b0, ANY},
      '{ROW_BEAT, TICK, KEEP, 1'b0, ANY},
      '{ROW_BEAT, TICK, KEEP, 1'b0, ANY},
      '{ROW_BEAT, '{MODE_COMMAND, WHEEL_LEFT, 11'sd0, 11'sd0}, KEEP, 1'b0, ANY},
      '{ROW_BEAT, TICK, KEEP, 1'b0, ANY},
      '{ROW_BEAT, '{MODE_COMMAND, WHEEL_RIGHT, 11'sd0, 11'sd0}, KEEP, 1'b0, ANY},
      '{ROW_BEAT, TICK, KEEP, 1'b0, ANY},
      '{ROW_BEAT, TICK, KEEP, 1'b0, ANY},
      '{ROW_BEAT, '{MODE_COMMAND, WHEEL_STOP, 11'sd0, 11'sd0}, KEEP, 1'b0, ANY},
      '{ROW_BEAT, TICK, KEEP, 1'b0, ANY},
      '{ROW_BEAT, '{MODE_COMMAND, WHEEL_FORWARD, 11'sd0, 11'sd0}, KEEP, 1'b0, ANY},
      '{ROW_SETTINGS, TICK, SET_NO_STEP, 1'b0, ANY},
      '{ROW_BEAT, TICK, KEEP, 1'b0, ANY},
      '{ROW_SETTINGS, TICK, SET_DEADBAND, 1'b0, ANY},
      '{ROW_BEAT, '{MODE_COMMAND, WHEEL_DIRECT, 11'sd999, -11'sd1}, KEEP, 1'b0, ANY},
      '{ROW_BEAT, TICK, KEEP, 1'b0, ANY},
      '{ROW_BEAT, '{MODE_COMMAND, WHEEL_DIRECT, -11'sd1001, 11'sd1001}, KEEP, 1'b0, ANY},
      '{ROW_SETTINGS, TICK, SET_QUICK_TIMEOUT, 1'b0, ANY},
      '{ROW_BEAT, TICK, KEEP, 1'b0, ANY},
      '{ROW_BEAT, TICK, KEEP, 1'b0, ANY},
      '{ROW_BEAT, TICK, KEEP, 1'b0, ANY},
      '{ROW_BEAT, '{MODE_COMMAND, WHEEL_DIRECT, -11'sd1000, 11'sd1000}, KEEP, 1'b0, ANY}
   };

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ddsr_req_if req_ch();
   ddsr_rsp_if rsp_ch();

   diff_drive_slew_ramp uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // predictor state
   logic [STEP_W-1:0] cfg_step = RAMP_STEP_RESET;
   logic [PERIOD_W-1:0] cfg_period = RAMP_PERIOD_RESET;
   logic [DEADBAND_W-1:0] cfg_deadband = DEADBAND_RESET;
   logic [TIMEOUT_W-1:0] cfg_timeout = TIMEOUT_RESET;
   logic signed [TARGET_W-1:0] left_cmd = '0;
   logic signed [TARGET_W-1:0] right_cmd = '0;
   logic signed [TARGET_W-1:0] left_speed = '0;
   logic signed [TARGET_W-1:0] right_speed = '0;
   logic [PERIOD_W-1:0] ramp_count = '0;
   logic [TIMEOUT_W-1:0] timeout_count = '0;
   drive_out_type held_drive = '0;

   drive_out_type pending_drive[$];
   row_note_type row_notes[$];
   drive_out_type want;
   row_note_type note;
   int mismatches = 0;
   int unsigned cycle_count = 0;
   bit idle_on = 1'b1;
   bit hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_diff_drive_slew_ramp failed");
         $finish;
      end
   end

   function automatic int clamp_full(int v);
      if (v > FULL_SPEED) return FULL_SPEED;
      if (v < -FULL_SPEED) return -FULL_SPEED;
      return v;
   endfunction

   function automatic int slew_toward(int cur, int cmd, int step);
      if (cmd > cur) return (cmd - cur > step) ? cur + step : cmd;
      if (cmd < cur) return (cur - cmd > step) ? cur - step : cmd;
      return cur;
   endfunction

   function automatic logic [6:0] duty_of(int speed);
      int mag;
      int duty;
      mag = (speed < 0) ? -speed : speed;
      duty = mag * DUTY_MAX / FULL_SPEED;
      if (duty < int'(cfg_deadband)) duty = 0;
      return 7'(duty);
   endfunction

   function automatic void set_commands(int l, int r);
      left_cmd = TARGET_W'(l);
      right_cmd = TARGET_W'(r);
   endfunction

   function automatic drive_out_type advance_drive(drive_beat_type b);
      drive_out_type r;
      int ramp_next;
      int timeout_next;
      logic updated;
      updated = 1'b0;
      if (b.mode == MODE_COMMAND) begin
         case (b.wheel_code)
            WHEEL_DIRECT: set_commands(clamp_full(int'(b.left_target)),
                                       clamp_full(int'(b.right_target)));
            WHEEL_FORWARD: set_commands(FULL_SPEED, FULL_SPEED);
            WHEEL_BACK: set_commands(-FULL_SPEED, -FULL_SPEED);
            WHEEL_LEFT: set_commands(-FULL_SPEED, FULL_SPEED);
            WHEEL_RIGHT: set_commands(FULL_SPEED, -FULL_SPEED);
            WHEEL_STOP: set_commands(0, 0);
            default: ;
         endcase
      end else begin
         ramp_next = int'(ramp_count) + 1;
         timeout_next = int'(timeout_count) + 1;
         if (ramp_next > int'(cfg_period)) begin
            ramp_count = '0;
            left_speed = TARGET_W'(slew_toward(int'(left_speed), int'(left_cmd),
                                               int'(cfg_step)));
            right_speed = TARGET_W'(slew_toward(int'(right_speed), int'(right_cmd),
                                                int'(cfg_step)));
            held_drive.left_pwm = duty_of(int'(left_speed));
            held_drive.right_pwm = duty_of(int'(right_speed));
            held_drive.left_forward = (left_speed > 0);
            held_drive.right_forward = (right_speed > 0);
            updated = 1'b1;
         end else begin
            ramp_count = PERIOD_W'(ramp_next);
         end
         if (timeout_next > int'(cfg_timeout)) begin
            timeout_count = '0;
            set_commands(0, 0);
         end else begin
            timeout_count = TIMEOUT_W'(timeout_next);
         end
      end
      r = held_drive;
      r.ramp_updated = updated;
      return r;
   endfunction

   function automatic void load_register(logic [CSR_INDEX_W-1:0] idx,
                                         logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_RAMP_STEP: cfg_step = STEP_W'(data);
         REG_RAMP_PERIOD: cfg_period = PERIOD_W'(data);
         REG_DEADBAND: cfg_deadband = DEADBAND_W'(data);
         REG_TIMEOUT: cfg_timeout = TIMEOUT_W'(data);
         default: ;
      endcase
   endfunction

   task automatic compare_field(input string name, input int exp_v, input int got_v);
      if (exp_v != got_v) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) load_register(csr_index, csr_wdata);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_drive.size() == 0) begin
               $display("%0t ns: result beat with nothing expected, actual %0d %0d %0b %0b %0b",
                        $time, rsp_ch.left_pwm, rsp_ch.right_pwm, rsp_ch.left_forward,
                        rsp_ch.right_forward, rsp_ch.ramp_updated);
               mismatches++;
            end else begin
               want = pending_drive.pop_front();
               compare_field("left_pwm", int'(want.left_pwm), int'(rsp_ch.left_pwm));
               compare_field("right_pwm", int'(want.right_pwm), int'(rsp_ch.right_pwm));
               compare_field("left_forward", int'(want.left_forward),
                             int'(rsp_ch.left_forward));
               compare_field("right_forward", int'(want.right_forward),
                             int'(rsp_ch.right_forward));
               compare_field("ramp_updated", int'(want.ramp_updated),
                             int'(rsp_ch.ramp_updated));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            note = row_notes.pop_front();
            want = advance_drive('{req_ch.mode, req_ch.wheel_code, req_ch.left_target,
                                   req_ch.right_target});
            pending_drive.push_back(note.known ? note.result : want);
         end
      end
   end

   // result side: random stalls plus one long hold-off
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_on) begin
            rsp_ch.ready <= ($urandom_range(99) >= 36);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_beat(input drive_beat_type b);
      if (idle_on && $urandom_range(99) < 36) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while (idle_on && $urandom_range(99) < 36);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= b.mode;
      req_ch.wheel_code <= b.wheel_code;
      req_ch.left_target <= b.left_target;
      req_ch.right_target <= b.right_target;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic settle_and_configure(input ramp_settings_type s);
      req_ch.valid <= 1'b0;
      // wait on the clock so the last accepted beat is already queued for checking
      @(posedge clock);
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= REG_RAMP_STEP;
      csr_wdata <= CSR_DATA_W'(s.step);
      @(posedge clock);
      csr_index <= REG_RAMP_PERIOD;
      csr_wdata <= CSR_DATA_W'(s.period);
      @(posedge clock);
      csr_index <= REG_DEADBAND;
      csr_wdata <= CSR_DATA_W'(s.deadband);
      @(posedge clock);
      csr_index <= REG_TIMEOUT;
      csr_wdata <= CSR_DATA_W'(s.timeout);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic ramp_settings_type random_settings();
      ramp_settings_type s;
      case ($urandom_range(3))
         0: s.step = 10'd1;
         1: s.step = 10'd1000;
         default: s.step = STEP_W'($urandom_range(1, 1000));
      endcase
      case ($urandom_range(7))
         0: s.period = 8'd255;
         1: s.period = PERIOD_W'($urandom_range(0, 255));
         default: s.period = PERIOD_W'($urandom_range(0, 4));
      endcase
      s.deadband = DEADBAND_W'($urandom_range(0, 100));
      case ($urandom_range(7))
         0: s.timeout = 16'd65535;
         1: s.timeout = TIMEOUT_W'($urandom_range(1, 65535));
         default: s.timeout = TIMEOUT_W'($urandom_range(1, 400));
      endcase
      return s;
   endfunction

   function automatic drive_beat_type random_beat();
      drive_beat_type b;
      b.mode = ($urandom_range(99) < 75) ? MODE_TICK : MODE_COMMAND;
      b.wheel_code = ($urandom_range(99) < 40) ? WHEEL_DIRECT : CODE_W'($urandom_range(1, 7));
      if ($urandom_range(1) == 0) begin
         b.left_target = TARGET_W'(int'($urandom_range(0, 2000)) - FULL_SPEED);
         b.right_target = TARGET_W'(int'($urandom_range(0, 2000)) - FULL_SPEED);
      end else begin
         b.left_target = TARGET_W'($urandom_range(0, 2047));
         b.right_target = TARGET_W'($urandom_range(0, 2047));
      end
      return b;
   endfunction

   initial begin
      ramp_settings_type corners[4];
      int sent;
      int phase;
      int burst;
      corners[0] = '{10'd1, 8'd0, 7'd0, 16'd65535};
      corners[1] = '{10'd1000, 8'd255, 7'd100, 16'd1};
      corners[2] = '{10'd1000, 8'd0, 7'd100, 16'd65535};
      corners[3] = '{10'd1, 8'd255, 7'd0, 16'd1};
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.mode <= MODE_TICK;
      req_ch.wheel_code <= WHEEL_DIRECT;
      req_ch.left_target <= '0;
      req_ch.right_target <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].kind == ROW_SETTINGS) begin
            settle_and_configure(directed_rows[i].settings);
         end else begin
            row_notes.push_back('{directed_rows[i].known, directed_rows[i].result});
            send_beat(directed_rows[i].beat);
         end
      end

      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         settle_and_configure((phase < 4) ? corners[phase] : random_settings());
         idle_on = (phase != 5);
         if (phase == 6) hold_request = 1'b1;
         burst = (phase == 5) ? 200 : $urandom_range(40, 120);
         repeat (burst) begin
            row_notes.push_back('0);
            send_beat(random_beat());
            sent++;
         end
         idle_on = 1'b1;
         phase++;
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_diff_drive_slew_ramp passed");
      end else begin
         $display("tb_diff_drive_slew_ramp failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/ddsr_pkg.sv
hw/rtl/ddsr_if.sv
hw/rtl/ddsr_front.sv
hw/rtl/ddsr_queue.sv
hw/rtl/ddsr_back.sv
hw/rtl/diff_drive_slew_ramp.sv
hw/rtl/ddsr_checker.sv
verif/tb_diff_drive_slew_ramp.sv
